@@ sv/oukl_pkg.sv @@
// Shared codes, field widths and defaults of the ordered unique key list.
package oukl_pkg;

   localparam int DefaultCapacity = 16;

   localparam int OpWidth     = 2;
   localparam int KeyWidth    = 32;
   localparam int StatusWidth = 2;
   localparam int PosWidth    = 5;

   typedef logic [OpWidth-1:0]     op_type;
   typedef logic [StatusWidth-1:0] status_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_SEARCH = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_DUPLICATE = 2'd1;
   localparam status_type ST_NOT_FOUND = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

endpackage

@@ sv/oukl_key_mem.sv @@
// Key store: one write port and one read port with registered read data.
module oukl_key_mem #(
   parameter int Depth = 16,
   parameter int AddrWidth = 4
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AddrWidth-1:0]          wr_addr,
   input  logic [oukl_pkg::KeyWidth-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [AddrWidth-1:0]          rd_addr,
   output logic [oukl_pkg::KeyWidth-1:0] rd_data
);
   import oukl_pkg::*;

   logic [KeyWidth-1:0] mem [Depth];
   logic [KeyWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ordered_unique_key_list.sv @@
// Ordered unique key list: control sequencer around the key store memory.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_operation, req_key
//   rsp     | out       | rsp_valid, rsp_ready, rsp_status, rsp_position, rsp_count
//
// A word searches the store one entry per cycle through the single read port and stops early
// at a match. A remove that finds its key at some position then moves each later key up one
// entry per cycle. An unused operation skips the search and goes straight to the result. A
// new request word is taken while the previous result word still waits. Reset clears the
// state, the key count and the result valid flag; the store needs no clearing pass. A
// stalled result holds the sequencer.
module ordered_unique_key_list #(
   parameter int CAPACITY = oukl_pkg::DefaultCapacity
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  oukl_pkg::op_type                 req_operation,
   input  logic signed [oukl_pkg::KeyWidth-1:0] req_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output oukl_pkg::status_type             rsp_status,
   output logic [oukl_pkg::PosWidth-1:0]    rsp_position,
   output logic [oukl_pkg::PosWidth-1:0]    rsp_count
);
   import oukl_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > PosWidth) ? CW : PosWidth;
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]          state_ff, state_in;
   op_type              op_ff, op_in;
   logic [KeyWidth-1:0] key_ff, key_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       slot_ff, slot_in;
   logic                found_ff, found_in;
   logic [CW-1:0]       count_ff, count_in;
   status_type          res_status_ff, res_status_in;
   logic [CW-1:0]       res_pos_ff, res_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [PosWidth-1:0] rsp_position_ff;
   logic [PosWidth-1:0] rsp_count_ff;

   logic                mem_wr_en;
   logic [IW-1:0]       mem_wr_addr;
   logic [KeyWidth-1:0] mem_wr_data;
   logic                mem_rd_en;
   logic [IW-1:0]       mem_rd_addr;
   logic [KeyWidth-1:0] mem_rd_data;
   logic                out_free;
   logic [XW-1:0]       pos_ext;
   logic [XW-1:0]       count_ext;

   oukl_key_mem #(
      .Depth(CAPACITY),
      .AddrWidth(IW)
   ) u_key_mem (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en(mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pos_ext   = XW'(res_pos_ff);
   assign count_ext = XW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_operation;
               key_in        = req_key;
               idx_in        = '0;
               found_in      = 1'b0;
               res_status_in = ST_OK;
               res_pos_in    = '0;
               if (!(req_operation inside {OP_INSERT, OP_REMOVE, OP_SEARCH})) begin
                  state_in = S_EMIT;
               end else if (count_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  mem_rd_en = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (mem_rd_data == key_ff) begin
               found_in = 1'b1;
               slot_in  = idx_ff;
               state_in = S_DECIDE;
            end else if (CW'(idx_ff) + CW'(1) == count_ff) begin
               state_in = S_DECIDE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + IW'(1);
               idx_in      = idx_ff + IW'(1);
            end
         end
         S_DECIDE: begin
            state_in = S_EMIT;
            case (op_ff)
               OP_INSERT: begin
                  if (found_ff) begin
                     res_status_in = ST_DUPLICATE;
                  end else if (count_ff >= CapCount) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = count_ff[IW-1:0];
                     mem_wr_data = key_ff;
                     count_in    = count_ff + CW'(1);
                     res_pos_in  = count_ff + CW'(1);
                  end
               end
               OP_REMOVE: begin
                  if (!found_ff) begin
                     res_status_in = ST_NOT_FOUND;
                  end else if (CW'(slot_ff) + CW'(1) == count_ff) begin
                     count_in = count_ff - CW'(1);
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = slot_ff + IW'(1);
                     idx_in      = slot_ff;
                     state_in    = S_SHIFT;
                  end
               end
               OP_SEARCH: begin
                  if (!found_ff) begin
                     res_status_in = ST_NOT_FOUND;
                  end else begin
                     res_pos_in = CW'(slot_ff) + CW'(1);
                  end
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         S_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = mem_rd_data;
            if (CW'(idx_ff) + CW'(2) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_EMIT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + IW'(2);
               idx_in      = idx_ff + IW'(1);
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      if (state_ff == S_EMIT && out_free) begin
         rsp_status_ff   <= res_status_ff;
         rsp_position_ff <= pos_ext[PosWidth-1:0];
         rsp_count_ff    <= count_ext[PosWidth-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

endmodule
